// ===== sv/dfte_pkg.sv =====
// ============================================================================
// dfte_pkg
// Shared types, codes and helpers for the disk flux transition encoder.
// ============================================================================
package dfte_pkg;

    // Default width of the running time counter
    localparam int TIME_BITS_DEF = 32;

    // Field widths
    localparam int REQ_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int CELL_W  = 16;
    localparam int FLUX_W  = 32;
    localparam int SHIFT_W = 24;
    localparam int CFG_W   = 16;

    typedef logic [REQ_W-1:0] t_req;

    // Request kinds
    localparam t_req REQ_FM   = 3'd0;
    localparam t_req REQ_MFM  = 3'd1;
    localparam t_req REQ_GCR  = 3'd2;
    localparam t_req REQ_SYNC = 3'd3;
    localparam t_req REQ_WEAK = 3'd4;

    // Configuration register indexes
    localparam logic CFG_BIT_CELL = 1'b0;
    localparam logic CFG_PRECOMP  = 1'b1;

    // Reset value of the bit cell length
    localparam logic [CFG_W-1:0] BIT_CELL_RST = 16'd640;

    // MFM cell shifter taps: cell leaving the window and its two-away neighbours
    localparam int CELL_OUT_BIT  = 15;
    localparam int ADJ_PRIOR_BIT = 17;
    localparam int ADJ_NEXT_BIT  = 13;

    // Cell counts per request kind
    localparam logic [4:0] CELLS_GCR  = 5'd8;
    localparam logic [4:0] CELLS_SYNC = 5'd10;
    localparam logic [4:0] CELLS_WEAK = 5'd11;

    // Spread eight bits onto the even positions of a 16-bit word
    function automatic logic [CELL_W-1:0] spread8(input logic [BYTE_W-1:0] v);
        logic [CELL_W-1:0] r;
        r = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            r[2*k] = v[k];
        end
        return r;
    endfunction

endpackage

// ===== sv/disk_flux_transition_encoder.sv =====
// ============================================================================
// disk_flux_transition_encoder
// Turns FM, MFM, GCR, sync and weak disk bytes into flux transition times.
// ============================================================================
//
// Channel   Dir  Handshake                       Payload
// --------  ---  ------------------------------  ---------------------------------
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: req_type; tdata: clock
//                                                pattern, data byte, bit count
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: flux_time; tlast: last
// cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// Steps: the item is taken, then each bit cell is stepped in turn (2 x bit_count
// for FM and MFM, 8 for GCR, 10 for sync, 11 for weak), with an extra step for
// each precompensated MFM transition that is not early, and the item closes with
// the end of count and then the hand-over of the final transition.
// The single time adder advances the time once per cell.
// Reset (synchronous, active low) clears time, cell history, sequencer and
// output; the cell length returns to 640 ticks and precompensation to off.
// A stall on m_axis holds the sequencer only when a further transition, or the
// final one, has to leave; the output register lets the sequencer run on.

module disk_flux_transition_encoder #(
    parameter int TIME_BITS = dfte_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tuser: [2:0] req_type
    input  logic [2:0]  s_axis_tuser,
    // tdata: [7:0] clock_pattern, [15:8] data_byte, [19:16] bit_count, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [31:0] flux_time
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam int ADD_W = 17;  // widest advance: 1.5 cells of a 16-bit cell

    // Configuration
    logic [15:0] r_bct;
    logic        r_precomp;

    // Datapath state
    logic [TIME_BITS-1:0]         r_time;
    logic [dfte_pkg::SHIFT_W-1:0] r_sh;     // MFM cell history, kept across items
    logic [dfte_pkg::CELL_W-1:0]  r_pat;    // cell pattern for FM, GCR, sync, weak
    logic [4:0]                   r_cnt;    // cells still to go
    dfte_pkg::t_req               r_mode;
    logic                         r_ofs;    // precomp: offset emitted, advance next
    logic [1:0]                   r_state;

    // Pending transition: held back until we know whether it is the last one
    logic                         r_pend_v;
    logic [dfte_pkg::FLUX_W-1:0]  r_pend_time;

    // Output register
    logic                         r_out_v;
    logic [dfte_pkg::FLUX_W-1:0]  r_out_time;
    logic                         r_out_last;

    // Input fields
    dfte_pkg::t_req              in_req;
    logic [dfte_pkg::BYTE_W-1:0] in_clk;
    logic [dfte_pkg::BYTE_W-1:0] in_dat;
    logic [dfte_pkg::COUNT_W-1:0] in_bits;
    logic [3:0]                  bits_sat;

    assign in_req  = s_axis_tuser;
    assign in_clk  = s_axis_tdata[7:0];
    assign in_dat  = s_axis_tdata[15:8];
    assign in_bits = s_axis_tdata[19:16];
    assign bits_sat = (in_bits > 4'd8) ? 4'd8 : in_bits;

    // MFM load: new data cells under the kept history, clocks where no neighbour
    logic [dfte_pkg::SHIFT_W-1:0] mfm_s0;
    logic [dfte_pkg::SHIFT_W-1:0] mfm_nb;
    logic [dfte_pkg::CELL_W-1:0]  mfm_clk;
    logic [dfte_pkg::SHIFT_W-1:0] mfm_cm;
    logic [dfte_pkg::SHIFT_W-1:0] mfm_s;

    always_comb begin
        mfm_s0  = {r_sh[23:16], dfte_pkg::spread8(in_dat)};
        mfm_nb  = {mfm_s0[22:0], 1'b0} | {1'b0, mfm_s0[23:1]};
        mfm_clk = dfte_pkg::spread8(in_clk);
        mfm_cm  = {8'd0, mfm_clk[14:0], 1'b0};
        mfm_s   = mfm_s0 | (~mfm_nb & mfm_cm);
    end

    // FM pattern: clock and data bits interleaved, clock first
    logic [dfte_pkg::CELL_W-1:0] fm_pat;
    always_comb begin
        fm_pat = '0;
        for (int k = 0; k < dfte_pkg::BYTE_W; k++) begin
            fm_pat[2*k+1] = in_clk[k];
            fm_pat[2*k]   = in_dat[k];
        end
    end

    // Weak spacing: floor and ceiling of 1.5 cells
    logic [ADD_W:0]   bct3;
    logic [ADD_W-1:0] weak_lo;
    logic [ADD_W-1:0] weak_hi;
    assign bct3    = {2'b00, r_bct} + {1'b0, r_bct, 1'b0};
    assign weak_lo = bct3[ADD_W:1];
    assign weak_hi = bct3[ADD_W:1] + {16'd0, bct3[0]};

    // Current cell and precompensation decision
    logic       cur_bit;
    logic [1:0] adj;
    logic       want_off;
    logic       emit;
    assign cur_bit = (r_mode == dfte_pkg::REQ_MFM) ? r_sh[dfte_pkg::CELL_OUT_BIT]
                                                   : r_pat[dfte_pkg::CELL_W-1];
    assign adj = {r_sh[dfte_pkg::ADJ_PRIOR_BIT], r_sh[dfte_pkg::ADJ_NEXT_BIT]};
    assign want_off = (r_mode == dfte_pkg::REQ_MFM) && cur_bit && r_precomp
                      && (adj != 2'b10) && !r_ofs;
    assign emit = cur_bit && !r_ofs;

    // Shared time adder: transition offset or cell advance
    logic [ADD_W-1:0]     addend;
    logic [TIME_BITS-1:0] sum;
    logic [TIME_BITS-1:0] emit_val;

    always_comb begin
        if (want_off) begin
            addend = (adj == 2'b01) ? {4'd0, r_bct[15:3]} : {5'd0, r_bct[15:4]};
        end else if (r_mode == dfte_pkg::REQ_WEAK) begin
            if (r_cnt == 5'd1) begin
                addend = {1'b0, r_bct};
            end else begin
                addend = r_cnt[0] ? weak_lo : weak_hi;
            end
        end else begin
            addend = {1'b0, r_bct};
        end
        sum      = r_time + TIME_BITS'(addend);
        emit_val = want_off ? sum : r_time;
    end

    logic out_free;
    assign out_free = !r_out_v || m_axis_tready;

    logic stall;
    assign stall = emit && r_pend_v && !out_free;

    // Next-state values
    logic [1:0]                   n_state;
    logic [TIME_BITS-1:0]         n_time;
    logic [dfte_pkg::SHIFT_W-1:0] n_sh;
    logic [dfte_pkg::CELL_W-1:0]  n_pat;
    logic [4:0]                   n_cnt;
    dfte_pkg::t_req               n_mode;
    logic                         n_ofs;
    logic                         n_pend_v;
    logic [dfte_pkg::FLUX_W-1:0]  n_pend_time;
    logic                         n_push;
    logic                         n_push_last;

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_sh        = r_sh;
        n_pat       = r_pat;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_ofs       = r_ofs;
        n_pend_v    = r_pend_v;
        n_pend_time = r_pend_time;
        n_push      = 1'b0;
        n_push_last = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode = in_req;
                    n_ofs  = 1'b0;
                    n_state = ST_RUN;
                    case (in_req)
                        dfte_pkg::REQ_FM: begin
                            n_pat = fm_pat;
                            n_cnt = {bits_sat, 1'b0};
                        end
                        dfte_pkg::REQ_MFM: begin
                            n_sh  = mfm_s;
                            n_cnt = {bits_sat, 1'b0};
                        end
                        dfte_pkg::REQ_GCR: begin
                            n_pat = {in_dat, 8'd0};
                            n_cnt = dfte_pkg::CELLS_GCR;
                        end
                        dfte_pkg::REQ_SYNC: begin
                            n_pat = {8'hFF, 8'd0};
                            n_cnt = dfte_pkg::CELLS_SYNC;
                        end
                        dfte_pkg::REQ_WEAK: begin
                            // ten transitions, then a silent closing cell
                            n_pat = {{10{1'b1}}, 6'd0};
                            n_cnt = dfte_pkg::CELLS_WEAK;
                        end
                        default: begin
                            // unknown kinds are dropped without effect
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (r_cnt == 5'd0) begin
                    n_state = ST_FLUSH;
                end else if (!stall) begin
                    if (emit) begin
                        n_pend_v    = 1'b1;
                        n_pend_time = dfte_pkg::FLUX_W'(emit_val);
                        n_push      = r_pend_v;
                    end
                    if (want_off) begin
                        n_ofs = 1'b1;
                    end else begin
                        n_ofs  = 1'b0;
                        n_time = sum;
                        n_cnt  = r_cnt - 5'd1;
                        if (r_mode == dfte_pkg::REQ_MFM) begin
                            n_sh = {r_sh[dfte_pkg::SHIFT_W-2:0], 1'b0};
                        end else begin
                            n_pat = {r_pat[dfte_pkg::CELL_W-2:0], 1'b0};
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_push      = 1'b1;
                    n_push_last = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_time    <= '0;
            r_sh      <= '0;
            r_cnt     <= '0;
            r_ofs     <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_bct     <= dfte_pkg::BIT_CELL_RST;
            r_precomp <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_time   <= n_time;
            r_sh     <= n_sh;
            r_cnt    <= n_cnt;
            r_ofs    <= n_ofs;
            r_pend_v <= n_pend_v;
            if (n_push) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    dfte_pkg::CFG_BIT_CELL: r_bct     <= i_cfg_data;
                    dfte_pkg::CFG_PRECOMP:  r_precomp <= i_cfg_data[0];
                    default:                r_bct     <= r_bct;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pat       <= n_pat;
        r_mode      <= n_mode;
        r_pend_time <= n_pend_time;
        if (n_push) begin
            r_out_time <= r_pend_time;
            r_out_last <= n_push_last;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_time;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== bench/disk_flux_transition_encoder_tb.sv =====
// ============================================================================
// disk_flux_transition_encoder_tb
// Self-checking bench for the FM / MFM / GCR / sync / weak flux transition encoder.
// A queue of disk bytes feeds a stream driver. A scoreboard predicts each
// flux timestamp at input acceptance and checks every output transfer in
// order. Phases cover several cell lengths and precompensation settings,
// with random idling on both sides, a long output hold-off and a drain pause.
// ============================================================================
`timescale 1ns / 100ps

module disk_flux_transition_encoder_tb;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 10;
    // Allow a comfortable margin for the block to settle after a drain
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLDOFF_LEN   = 400;
    localparam int MAX_FLUX      = 16;

    // Request codes the block must ignore
    localparam dfte_pkg::t_req REQ_UNDEF_FIRST = dfte_pkg::REQ_WEAK + 3'd1;
    localparam dfte_pkg::t_req REQ_UNDEF_LAST  = '1;

    typedef struct packed {
        dfte_pkg::t_req kind;
        logic [7:0]     clk_pat;
        logic [7:0]     dat;
        logic [3:0]     cnt;
    } t_disk_req;

    typedef struct packed {
        logic [31:0] stamp;
        logic        is_last;
    } t_flux_exp;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic [2:0]  s_axis_tuser  = '0;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index   = 1'b0;
    logic [15:0] i_cfg_data    = '0;

    // Stimulus and scoreboard state
    t_disk_req req_pend_q[$];
    t_flux_exp flux_exp_q[$];
    t_disk_req drv_req;
    bit        in_taken     = 1'b0;
    bit        tx_hold      = 1'b0;
    int        tx_idle_pct  = 0;
    int        rx_stall_pct = 0;
    int        rx_hold_left = 0;
    int        err_count    = 0;
    int        stall_cycles = 0;

    // Mirror of the encoder state
    logic [31:0] flux_clock = '0;
    logic [23:0] mfm_hist   = '0;
    logic [15:0] cell_len   = dfte_pkg::BIT_CELL_RST;
    logic        precomp_on = 1'b0;

    disk_flux_transition_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tuser  (s_axis_tuser),   // [2:0] req_type
        .s_axis_tdata  (s_axis_tdata),   // [7:0] clock, [15:8] data, [19:16] count
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] flux_time
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Eight bits onto the even positions of a 16-bit cell word
    function automatic logic [15:0] interleave_zero(input logic [7:0] v);
        return {1'b0, v[7], 1'b0, v[6], 1'b0, v[5], 1'b0, v[4],
                1'b0, v[3], 1'b0, v[2], 1'b0, v[1], 1'b0, v[0]};
    endfunction

    // Work out the flux timestamps of one accepted byte and queue them
    function automatic void predict_flux(input t_disk_req r);
        logic [31:0] stamps[$];
        logic [23:0] cells;
        logic [23:0] clk_mask;
        logic [7:0]  cp;
        logic [7:0]  db;
        int          n_bits;
        t_flux_exp   e;

        cp     = r.clk_pat;
        db     = r.dat;
        n_bits = (r.cnt > 8) ? 8 : int'(r.cnt);

        case (r.kind)
            dfte_pkg::REQ_FM: begin
                // clock transition at pair start, data transition one cell on
                for (int k = 0; k < n_bits; k++) begin
                    if (cp[7]) stamps.insert(stamps.size(), flux_clock);
                    if (db[7]) stamps.insert(stamps.size(), flux_clock + 32'(cell_len));
                    cp = cp << 1;
                    db = db << 1;
                    flux_clock = flux_clock + 32'(cell_len) * 2;
                end
            end
            dfte_pkg::REQ_MFM: begin
                cells    = {mfm_hist[23:16], 16'h0000} | {8'h00, interleave_zero(db)};
                clk_mask = {7'h00, interleave_zero(cp), 1'b0};
                // clock cell wherever neither neighbour carries a transition
                cells    = cells | (~((cells << 1) | (cells >> 1)) & clk_mask);
                for (int k = 0; k < n_bits * 2; k++) begin
                    if (cells[15]) begin
                        if (!precomp_on)
                            stamps.insert(stamps.size(), flux_clock);
                        else if (cells[17] && !cells[13])
                            stamps.insert(stamps.size(), flux_clock);
                        else if (!cells[17] && cells[13])
                            stamps.insert(stamps.size(),
                                          flux_clock + 32'(cell_len >> 3));
                        else
                            stamps.insert(stamps.size(),
                                          flux_clock + 32'(cell_len >> 4));
                    end
                    cells      = cells << 1;
                    flux_clock = flux_clock + 32'(cell_len);
                end
                mfm_hist = cells;
            end
            dfte_pkg::REQ_GCR, dfte_pkg::REQ_SYNC: begin
                if (r.kind == dfte_pkg::REQ_SYNC) db = 8'hFF;
                for (int k = 0; k < 8; k++) begin
                    if (db[7]) stamps.insert(stamps.size(), flux_clock);
                    db = db << 1;
                    flux_clock = flux_clock + 32'(cell_len);
                end
                // two-cell slip after a sync byte
                if (r.kind == dfte_pkg::REQ_SYNC)
                    flux_clock = flux_clock + 32'(cell_len) * 2;
            end
            dfte_pkg::REQ_WEAK: begin
                // alternating floor / ceiling of 1.5 cells
                for (int k = 0; k < 5; k++) begin
                    stamps.insert(stamps.size(), flux_clock);
                    flux_clock = flux_clock + ((32'(cell_len) * 3) >> 1);
                    stamps.insert(stamps.size(), flux_clock);
                    flux_clock = flux_clock + ((32'(cell_len) * 3 + 1) >> 1);
                end
                flux_clock = flux_clock + 32'(cell_len);
            end
            default: ;
        endcase

        for (int k = 0; k < stamps.size() && k < MAX_FLUX; k++) begin
            e.stamp   = stamps[k];
            e.is_last = (k == stamps.size() - 1) || (k == MAX_FLUX - 1);
            flux_exp_q.insert(flux_exp_q.size(), e);
        end
    endfunction

    // Input driver: a new byte goes on the bus after the previous transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (!tx_hold && req_pend_q.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct) begin
                drv_req = req_pend_q.pop_front();
                s_axis_tuser  <= drv_req.kind;
                s_axis_tdata  <= {4'h0, drv_req.cnt, drv_req.dat, drv_req.clk_pat};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure: random stalls, or a counted hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Scoreboard: check outputs, predict on input acceptance, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (flux_exp_q.size() == 0) begin
                    $display("%0t: unexpected transfer: expected none, got %0d last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                    err_count++;
                end else begin
                    t_flux_exp e;
                    e = flux_exp_q.pop_front();
                    if (m_axis_tdata !== e.stamp) begin
                        $display("%0t: flux time mismatch: expected %0d, got %0d",
                                 $time, e.stamp, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== e.is_last) begin
                        $display("%0t: tlast mismatch at time %0d: expected %0b, got %0b",
                                 $time, e.stamp, e.is_last, m_axis_tlast);
                        err_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_flux(drv_req);
                in_taken = 1'b1;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == dfte_pkg::CFG_BIT_CELL)
            cell_len = val;
        else
            precomp_on = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_req(input dfte_pkg::t_req kind, input logic [7:0] clk_pat,
                             input logic [7:0] dat, input logic [3:0] cnt);
        t_disk_req r;
        r.kind    = kind;
        r.clk_pat = clk_pat;
        r.dat     = dat;
        r.cnt     = cnt;
        req_pend_q.insert(req_pend_q.size(), r);
    endtask

    // Random bytes, MFM the most frequent kind, mostly well-formed with normal clocking;
    // ignored request codes are sprinkled in but not counted
    task automatic queue_random(input int n_items);
        int        done;
        int        pick;
        t_disk_req r;
        done = 0;
        while (done < n_items) begin
            r.dat = 8'($urandom);
            r.cnt = ($urandom_range(99) < 85) ? 4'($urandom_range(8, 1))
                                               : 4'($urandom_range(15, 0));
            r.clk_pat = ($urandom_range(99) < 75) ? 8'hFF : 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 4) begin
                r.kind = dfte_pkg::t_req'($urandom_range(REQ_UNDEF_LAST, REQ_UNDEF_FIRST));
            end else begin
                done++;
                case ($urandom_range(9))
                    0, 1:    r.kind = dfte_pkg::REQ_FM;
                    6:       r.kind = dfte_pkg::REQ_GCR;
                    7:       r.kind = dfte_pkg::REQ_SYNC;
                    8:       r.kind = dfte_pkg::REQ_WEAK;
                    default: r.kind = dfte_pkg::REQ_MFM;
                endcase
            end
            req_pend_q.insert(req_pend_q.size(), r);
        end
    endtask

    // Wait until everything sent has come out, then let the block settle
    task automatic drain;
        while (req_pend_q.size() != 0 || s_axis_tvalid || flux_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 640-tick cells, no precompensation, no idling.
        // Directed bytes first.
        queue_req(dfte_pkg::REQ_FM,   8'hFF, 8'hFF, 4'd8);    // sixteen transitions
        queue_req(dfte_pkg::REQ_FM,   8'h00, 8'h00, 4'd8);    // nothing to emit
        queue_req(dfte_pkg::REQ_FM,   8'hC7, 8'hA1, 4'd4);
        queue_req(dfte_pkg::REQ_FM,   8'hFF, 8'hFF, 4'd0);    // zero count, no advance
        queue_req(dfte_pkg::REQ_FM,   8'hAA, 8'h55, 4'd15);   // count saturates at eight
        queue_req(dfte_pkg::REQ_MFM,  8'hFF, 8'h00, 4'd8);    // clocks only
        queue_req(dfte_pkg::REQ_MFM,  8'hFF, 8'hFF, 4'd8);
        queue_req(dfte_pkg::REQ_MFM,  8'hFB, 8'hA1, 4'd8);    // sync mark, missing clock
        queue_req(dfte_pkg::REQ_MFM,  8'hFF, 8'h4E, 4'd0);    // loads history only
        queue_req(dfte_pkg::REQ_MFM,  8'hFF, 8'h81, 4'd15);
        queue_req(dfte_pkg::REQ_MFM,  8'h00, 8'h00, 4'd8);    // clock mask shut
        queue_req(dfte_pkg::REQ_GCR,  8'hFF, 8'hFF, 4'd15);   // unused fields set
        queue_req(dfte_pkg::REQ_GCR,  8'h00, 8'h00, 4'd0);
        queue_req(dfte_pkg::REQ_GCR,  8'h5A, 8'h96, 4'd3);
        queue_req(dfte_pkg::REQ_SYNC, 8'hAA, 8'h00, 4'd15);
        queue_req(dfte_pkg::REQ_WEAK, 8'h00, 8'hFF, 4'd0);
        for (int k = REQ_UNDEF_FIRST; k <= REQ_UNDEF_LAST; k++)
            queue_req(dfte_pkg::t_req'(k), 8'hFF, 8'hFF, 4'hF);
        queue_random(15);
        drain();

        // Longest cell with precompensation; sender idles
        write_reg(dfte_pkg::CFG_BIT_CELL, 16'hFFFF);
        write_reg(dfte_pkg::CFG_PRECOMP, 16'd1);
        tx_idle_pct = 69;
        queue_req(dfte_pkg::REQ_MFM, 8'hFF, 8'h88, 4'd8);     // late and early shifts
        queue_req(dfte_pkg::REQ_MFM, 8'hFF, 8'h11, 4'd8);
        queue_req(dfte_pkg::REQ_MFM, 8'hFF, 8'h0A, 4'd8);
        queue_req(dfte_pkg::REQ_MFM, 8'hFF, 8'h50, 4'd8);
        queue_req(dfte_pkg::REQ_MFM, 8'hFF, 8'hA5, 4'd8);
        queue_random(45);
        drain();

        // Zero cell length: every transition of a byte shares one time
        write_reg(dfte_pkg::CFG_BIT_CELL, 16'h0000);
        tx_idle_pct  = 0;
        rx_stall_pct = 69;
        queue_random(45);
        drain();

        // Shortest non-zero cell, precompensation off, both sides idle
        write_reg(dfte_pkg::CFG_BIT_CELL, 16'h0001);
        write_reg(dfte_pkg::CFG_PRECOMP, 16'd0);
        tx_idle_pct  = 31;
        rx_stall_pct = 31;
        queue_random(50);
        drain();

        // Output held off for a long stretch while bytes keep coming
        write_reg(dfte_pkg::CFG_BIT_CELL, 16'($urandom_range(4000, 2)));
        write_reg(dfte_pkg::CFG_PRECOMP, 16'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = HOLDOFF_LEN;
        queue_random(50);
        drain();

        // Odd cell length; sender pauses mid-phase until all results are in
        write_reg(dfte_pkg::CFG_BIT_CELL, 16'd17);
        tx_idle_pct  = 31;
        rx_stall_pct = 31;
        queue_random(40);
        while (req_pend_q.size() > 20) @(posedge i_clk);
        tx_hold = 1'b1;
        while (s_axis_tvalid || flux_exp_q.size() != 0) @(posedge i_clk);
        tx_hold = 1'b0;
        drain();

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dfte_pkg.sv
sv/disk_flux_transition_encoder.sv
bench/disk_flux_transition_encoder_tb.sv
